// ===== design/kbl_pkg.sv =====
package kbl_pkg;

    localparam int TABLE_ENTRIES = 101;

    localparam logic [1:0] MODE_KEY   = 2'd0;
    localparam logic [1:0] MODE_DATA  = 2'd1;
    localparam logic [1:0] MODE_FLAG  = 2'd2;
    localparam logic [1:0] MODE_COUNT = 2'd3;

    localparam logic [8:0] SC_A         = 9'h004;
    localparam logic [8:0] SC_Z         = 9'h01D;
    localparam logic [8:0] SC_1         = 9'h01E;
    localparam logic [8:0] SC_BACKSPACE = 9'h02A;
    localparam logic [8:0] SC_CAPSLOCK  = 9'h039;
    localparam logic [8:0] SC_KP_1      = 9'h059;
    localparam logic [8:0] SC_KP_0      = 9'h062;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 48;

    // One table row, indexed by ctrl plus two times shift.
    typedef logic [3:0][6:0] t_row;

    typedef struct packed {
        logic [1:0] mode;
        logic [8:0] scan_code;
        logic       ctrl_down;
        logic       shift_down;
        logic       host_caps_on;
        logic       num_lock_on;
        logic       key_held;
    } t_item;

    typedef struct packed {
        logic       reset_request;
        logic       caps_status;
        logic [31:0] query_count;
        logic [7:0] read_data;
    } t_result;

    // Columns are listed from column 3 down to column 0.
    function automatic t_row code_rom(input logic [6:0] row);
        t_row r;
        r = '0;
        case (row)
            7'd4:   r = {7'h01, 7'h41, 7'h01, 7'h61};
            7'd5:   r = {7'h02, 7'h42, 7'h02, 7'h62};
            7'd6:   r = {7'h03, 7'h43, 7'h03, 7'h63};
            7'd7:   r = {7'h04, 7'h44, 7'h04, 7'h64};
            7'd8:   r = {7'h05, 7'h45, 7'h05, 7'h65};
            7'd9:   r = {7'h06, 7'h46, 7'h06, 7'h66};
            7'd10:  r = {7'h07, 7'h47, 7'h07, 7'h67};
            7'd11:  r = {7'h08, 7'h48, 7'h08, 7'h68};
            7'd12:  r = {7'h09, 7'h49, 7'h09, 7'h69};
            7'd13:  r = {7'h0A, 7'h4A, 7'h0A, 7'h6A};
            7'd14:  r = {7'h0B, 7'h4B, 7'h0B, 7'h6B};
            7'd15:  r = {7'h0C, 7'h4C, 7'h0C, 7'h6C};
            7'd16:  r = {7'h0D, 7'h4D, 7'h0D, 7'h6D};
            7'd17:  r = {7'h0E, 7'h4E, 7'h0E, 7'h6E};
            7'd18:  r = {7'h0F, 7'h4F, 7'h0F, 7'h6F};
            7'd19:  r = {7'h10, 7'h50, 7'h10, 7'h70};
            7'd20:  r = {7'h11, 7'h51, 7'h11, 7'h71};
            7'd21:  r = {7'h12, 7'h52, 7'h12, 7'h72};
            7'd22:  r = {7'h13, 7'h53, 7'h13, 7'h73};
            7'd23:  r = {7'h14, 7'h54, 7'h14, 7'h74};
            7'd24:  r = {7'h15, 7'h55, 7'h15, 7'h75};
            7'd25:  r = {7'h16, 7'h56, 7'h16, 7'h76};
            7'd26:  r = {7'h17, 7'h57, 7'h17, 7'h77};
            7'd27:  r = {7'h18, 7'h58, 7'h18, 7'h78};
            7'd28:  r = {7'h19, 7'h59, 7'h19, 7'h79};
            7'd29:  r = {7'h1A, 7'h5A, 7'h1A, 7'h7A};
            7'd30:  r = {7'h21, 7'h21, 7'h31, 7'h31};
            7'd31:  r = {7'h00, 7'h40, 7'h00, 7'h32};
            7'd32:  r = {7'h23, 7'h23, 7'h33, 7'h33};
            7'd33:  r = {7'h24, 7'h24, 7'h34, 7'h34};
            7'd34:  r = {7'h25, 7'h25, 7'h35, 7'h35};
            7'd35:  r = {7'h1E, 7'h5E, 7'h1E, 7'h36};
            7'd36:  r = {7'h26, 7'h26, 7'h37, 7'h37};
            7'd37:  r = {7'h2A, 7'h2A, 7'h38, 7'h38};
            7'd38:  r = {7'h28, 7'h28, 7'h39, 7'h39};
            7'd39:  r = {7'h29, 7'h29, 7'h30, 7'h30};
            7'd40:  r = {7'h0D, 7'h0D, 7'h0D, 7'h0D};
            7'd41:  r = {7'h1B, 7'h1B, 7'h1B, 7'h1B};
            7'd42:  r = {7'h7F, 7'h08, 7'h7F, 7'h08};
            7'd43:  r = {7'h09, 7'h09, 7'h09, 7'h09};
            7'd44:  r = {7'h20, 7'h20, 7'h20, 7'h20};
            7'd45:  r = {7'h1F, 7'h5F, 7'h1F, 7'h2D};
            7'd46:  r = {7'h2B, 7'h2B, 7'h3D, 7'h3D};
            7'd47:  r = {7'h1B, 7'h7B, 7'h1B, 7'h5B};
            7'd48:  r = {7'h1D, 7'h7D, 7'h1D, 7'h5D};
            7'd49:  r = {7'h1C, 7'h7C, 7'h1C, 7'h5C};
            7'd50:  r = {7'h1C, 7'h7C, 7'h1C, 7'h5C};
            7'd51:  r = {7'h3A, 7'h3A, 7'h3B, 7'h3B};
            7'd52:  r = {7'h20, 7'h22, 7'h27, 7'h27};
            7'd53:  r = {7'h7E, 7'h7E, 7'h60, 7'h60};
            7'd54:  r = {7'h3C, 7'h3C, 7'h2C, 7'h2C};
            7'd55:  r = {7'h3E, 7'h3E, 7'h2E, 7'h2E};
            7'd56:  r = {7'h3F, 7'h3F, 7'h2F, 7'h2F};
            7'd76:  r = {7'h7F, 7'h7F, 7'h7F, 7'h7F};
            7'd79:  r = {7'h15, 7'h15, 7'h15, 7'h15};
            7'd80:  r = {7'h08, 7'h08, 7'h08, 7'h08};
            7'd81:  r = {7'h0A, 7'h0A, 7'h0A, 7'h0A};
            7'd82:  r = {7'h0B, 7'h0B, 7'h0B, 7'h0B};
            7'd84:  r = {7'h2F, 7'h2F, 7'h2F, 7'h2F};
            7'd85:  r = {7'h2A, 7'h2A, 7'h2A, 7'h2A};
            7'd86:  r = {7'h2D, 7'h2D, 7'h2D, 7'h2D};
            7'd87:  r = {7'h2B, 7'h2B, 7'h2B, 7'h2B};
            7'd88:  r = {7'h0D, 7'h0D, 7'h0D, 7'h0D};
            7'd89:  r = {7'h31, 7'h31, 7'h31, 7'h31};
            7'd90:  r = {7'h0A, 7'h0A, 7'h0A, 7'h0A};
            7'd91:  r = {7'h33, 7'h33, 7'h33, 7'h33};
            7'd92:  r = {7'h08, 7'h08, 7'h08, 7'h08};
            7'd93:  r = {7'h35, 7'h35, 7'h35, 7'h35};
            7'd94:  r = {7'h15, 7'h15, 7'h15, 7'h15};
            7'd95:  r = {7'h37, 7'h37, 7'h37, 7'h37};
            7'd96:  r = {7'h0B, 7'h0B, 7'h0B, 7'h0B};
            7'd97:  r = {7'h39, 7'h39, 7'h39, 7'h39};
            7'd98:  r = {7'h30, 7'h30, 7'h30, 7'h30};
            7'd99:  r = {7'h2E, 7'h2E, 7'h2E, 7'h2E};
            7'd100: r = {7'h7E, 7'h7E, 7'h60, 7'h60};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/keyboard_latch_with_strobe.sv =====
// An accepted word is first held in the input register and then moves into the result register,
// from which it is offered on the output until it is taken.
// Throughput: one word per cycle; the input register and the result register form a
// two-stage pipeline that advances whenever the result register is free or being taken.
// Reset (synchronous, active low) empties both stages, clears latch, strobe and read count,
// and sets the caps flag and the machine type register to one.
module keyboard_latch_with_strobe (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // machine_is_iie
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [8:0] scan_code, [9] ctrl_down, [10] shift_down, [11] host_caps_on,
    // [12] num_lock_on, [13] key_held, [15:14] zero
    input  logic [kbl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,    // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [39:8] query_count, [40] caps_status, [41] reset_request, [47:42] zero
    output logic [kbl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic            r_machine_iie;
    logic            r_in_valid;
    kbl_pkg::t_item  r_in;
    logic            r_out_valid;
    kbl_pkg::t_result r_out;

    logic [6:0]  r_latch;
    logic        r_strobe;
    logic        r_caps;
    logic [31:0] r_read_count;

    logic [6:0]  n_latch;
    logic        n_strobe;
    logic        n_caps;
    logic [31:0] n_read_count;
    kbl_pkg::t_result n_out;

    logic        w_advance;
    logic        w_in_table;
    logic        w_shift;
    logic [6:0]  w_row;
    logic [1:0]  w_col;
    logic [6:0]  w_code;
    kbl_pkg::t_row w_rom_row;

    assign o_cfg_ready   = 1'b1;
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(kbl_pkg::OUT_DATA_W - $bits(kbl_pkg::t_result)){1'b0}}, r_out};

    always_comb begin
        n_latch      = r_latch;
        n_strobe     = r_strobe;
        n_caps       = r_caps;
        n_read_count = r_read_count;
        n_out        = '0;
        w_in_table   = r_in.scan_code < 9'(kbl_pkg::TABLE_ENTRIES);
        w_shift      = r_in.shift_down;
        w_row        = r_in.scan_code[6:0];

        // Caps lock is looked at before the letter forcing below.
        if (r_in.mode == kbl_pkg::MODE_KEY && r_in.scan_code == kbl_pkg::SC_CAPSLOCK
            && r_machine_iie) begin
            n_caps = r_in.host_caps_on;
        end
        if (r_in.scan_code >= kbl_pkg::SC_A && r_in.scan_code <= kbl_pkg::SC_Z
            && (n_caps || !r_machine_iie)) begin
            w_shift = 1'b1;
        end
        if (r_in.scan_code >= kbl_pkg::SC_KP_1 && r_in.scan_code <= kbl_pkg::SC_KP_0
            && r_in.num_lock_on) begin
            w_row = r_in.scan_code[6:0] - kbl_pkg::SC_KP_1[6:0] + kbl_pkg::SC_1[6:0];
        end
        w_col     = {w_shift, r_in.ctrl_down};
        w_rom_row = kbl_pkg::code_rom(w_row);
        w_code    = w_rom_row[w_col];

        case (r_in.mode)
            kbl_pkg::MODE_KEY: begin
                n_out.reset_request = r_in.scan_code == kbl_pkg::SC_BACKSPACE
                                      && r_in.ctrl_down && r_in.shift_down;
                if (w_in_table) begin
                    n_latch  = w_code;
                    n_strobe = w_code != 7'd0;
                end
            end
            kbl_pkg::MODE_DATA: begin
                n_read_count    = r_read_count + 32'd1;
                n_out.read_data = {r_strobe, r_latch};
            end
            kbl_pkg::MODE_FLAG: begin
                n_read_count    = r_read_count + 32'd1;
                n_strobe        = 1'b0;
                n_out.read_data = {r_in.key_held, r_latch};
            end
            default: begin
                n_out.query_count = r_read_count;
                n_read_count      = '0;
            end
        endcase
        n_out.caps_status = n_caps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_machine_iie <= 1'b1;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_latch       <= '0;
            r_strobe      <= 1'b0;
            r_caps        <= 1'b1;
            r_read_count  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_machine_iie <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid  <= 1'b1;
                r_latch      <= n_latch;
                r_strobe     <= n_strobe;
                r_caps       <= n_caps;
                r_read_count <= n_read_count;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.mode         <= s_axis_tuser;
            r_in.scan_code    <= s_axis_tdata[8:0];
            r_in.ctrl_down    <= s_axis_tdata[9];
            r_in.shift_down   <= s_axis_tdata[10];
            r_in.host_caps_on <= s_axis_tdata[11];
            r_in.num_lock_on  <= s_axis_tdata[12];
            r_in.key_held     <= s_axis_tdata[13];
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // The strobe is only ever set together with a nonzero code in the latch.
    a_strobe_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_latch != 7'd0)
        else $error("strobe set with an empty latch");

    a_flag_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.mode == kbl_pkg::MODE_FLAG) |=> !r_strobe)
        else $error("flag read did not clear the strobe");

    a_count_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.mode == kbl_pkg::MODE_COUNT) |=> r_read_count == 32'd0)
        else $error("count query did not clear the read count");

    a_off_table_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in.mode == kbl_pkg::MODE_KEY && !w_in_table)
        |=> (r_latch == $past(r_latch) && r_strobe == $past(r_strobe)))
        else $error("scan code beyond the table changed the latch");

endmodule
